>>> rtl/undocumented_opcode_executor_defines.svh
// Assertion macros used by the executor RTL
`ifndef UNDOCUMENTED_OPCODE_EXECUTOR_DEFINES_SVH
`define UNDOCUMENTED_OPCODE_EXECUTOR_DEFINES_SVH
// implication checked on every clock outside reset
`define UOE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// implication checked in the cycle after the antecedent
`define UOE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

>>> rtl/uoe_pkg.sv
// ----------------------------------------------------------------------------
// uoe_pkg
// Types, codes and the opcode decoder of the undocumented opcode executor.
// ----------------------------------------------------------------------------
package uoe_pkg;
	localparam int DEF_MEM_DEPTH = 65536;

	localparam logic [1:0] KIND_EXEC  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_LOAD  = 2'd3;

	typedef enum logic [3:0] {
		OP_LAX, OP_SAX, OP_DCP, OP_ISC, OP_ALR, OP_ARR, OP_ANC,
		OP_SLO, OP_SRE, OP_RLA, OP_RRA
	} op_t;

	typedef enum logic [3:0] {
		M_ABS, M_ABSX, M_ABSY, M_ZP, M_ZPX, M_ZPY, M_INDX, M_INDY, M_IMM
	} mode_t;

	typedef struct packed {
		logic        ok;
		op_t         op;
		mode_t       mode;
	} dec_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  opcode;
		logic [15:0] operand;
		logic [7:0]  write_byte;
		logic [7:0]  load_a;
		logic [7:0]  load_x;
		logic [7:0]  load_y;
		logic [15:0] load_pc;
		logic [3:0]  load_flags;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_a;
		logic [7:0]  out_x;
		logic [7:0]  out_y;
		logic [15:0] out_pc;
		logic [3:0]  out_flags;
		logic [7:0]  read_data;
		logic        bad_opcode;
	} out_item_t;

	function automatic dec_t decode(input logic [7:0] opc);
		dec_t d;
		d = '{ok: 1'b1, op: OP_LAX, mode: M_ABS};
		case (opc)
			8'hAF: begin d.op = OP_LAX; d.mode = M_ABS;  end
			8'hBF: begin d.op = OP_LAX; d.mode = M_ABSY; end
			8'hA7: begin d.op = OP_LAX; d.mode = M_ZP;   end
			8'hB7: begin d.op = OP_LAX; d.mode = M_ZPY;  end
			8'hB3: begin d.op = OP_LAX; d.mode = M_INDY; end
			8'h8F: begin d.op = OP_SAX; d.mode = M_ABS;  end
			8'h87: begin d.op = OP_SAX; d.mode = M_ZP;   end
			8'h97: begin d.op = OP_SAX; d.mode = M_ZPY;  end
			8'h83: begin d.op = OP_SAX; d.mode = M_INDX; end
			8'hCF: begin d.op = OP_DCP; d.mode = M_ABS;  end
			8'hC7: begin d.op = OP_DCP; d.mode = M_ZP;   end
			8'hEF: begin d.op = OP_ISC; d.mode = M_ABS;  end
			8'hE7: begin d.op = OP_ISC; d.mode = M_ZP;   end
			8'h4B: begin d.op = OP_ALR; d.mode = M_IMM;  end
			8'h6B: begin d.op = OP_ARR; d.mode = M_IMM;  end
			8'h0B: begin d.op = OP_ANC; d.mode = M_IMM;  end
			8'h0F: begin d.op = OP_SLO; d.mode = M_ABS;  end
			8'h1F: begin d.op = OP_SLO; d.mode = M_ABSX; end
			8'h1B: begin d.op = OP_SLO; d.mode = M_ABSY; end
			8'h07: begin d.op = OP_SLO; d.mode = M_ZP;   end
			8'h17: begin d.op = OP_SLO; d.mode = M_ZPX;  end
			8'h03: begin d.op = OP_SLO; d.mode = M_INDX; end
			8'h13: begin d.op = OP_SLO; d.mode = M_INDY; end
			8'h4F: begin d.op = OP_SRE; d.mode = M_ABS;  end
			8'h47: begin d.op = OP_SRE; d.mode = M_ZP;   end
			8'h2F: begin d.op = OP_RLA; d.mode = M_ABS;  end
			8'h27: begin d.op = OP_RLA; d.mode = M_ZP;   end
			8'h6F: begin d.op = OP_RRA; d.mode = M_ABS;  end
			8'h67: begin d.op = OP_RRA; d.mode = M_ZP;   end
			default: d.ok = 1'b0;
		endcase
		return d;
	endfunction
endpackage

>>> rtl/uoe_alu.sv
// ----------------------------------------------------------------------------
// uoe_alu
// Combinational operation unit: new A, X, flags and memory byte for one op.
// ----------------------------------------------------------------------------
module uoe_alu import uoe_pkg::*; (
	input  op_t        op,
	input  logic [7:0] a,
	input  logic [7:0] x,
	input  logic [3:0] flags,
	input  logic [7:0] m,
	output logic [7:0] new_a,
	output logic [7:0] new_x,
	output logic [3:0] new_flags,
	output logic [7:0] mem_byte,
	output logic       mem_wr
);
	logic       c;
	logic [7:0] r;
	logic [8:0] t;
	logic [7:0] anded;
	logic       nf, vf, zf, cf;

	always_comb begin
		c = flags[0];
		new_a = a;
		new_x = x;
		nf = flags[3];
		vf = flags[2];
		zf = flags[1];
		cf = flags[0];
		r = 8'h00;
		t = 9'h000;
		mem_wr = 1'b0;
		anded = a & m;
		unique case (op)
			OP_LAX: begin
				new_a = m;
				new_x = m;
			end
			OP_SAX: begin
				r = a & x;
				mem_wr = 1'b1;
			end
			OP_DCP: begin
				r = m - 8'd1;
				mem_wr = 1'b1;
				cf = (a >= r);
			end
			OP_ISC: begin
				r = m + 8'd1;
				mem_wr = 1'b1;
				t = {1'b0, a} + {1'b0, ~r} + {8'd0, c};
				cf = t[8];
				vf = (a[7] ^ t[7]) & (~r[7] ^ t[7]);
				new_a = t[7:0];
			end
			OP_ALR: begin
				cf = anded[0];
				new_a = {1'b0, anded[7:1]};
			end
			OP_ARR: begin
				new_a = {c, anded[7:1]};
				cf = new_a[6];
				vf = new_a[6] ^ new_a[5];
			end
			OP_ANC: begin
				new_a = anded;
				cf = anded[7];
			end
			OP_SLO: begin
				cf = m[7];
				r = {m[6:0], 1'b0};
				mem_wr = 1'b1;
				new_a = a | r;
			end
			OP_SRE: begin
				cf = m[0];
				r = {1'b0, m[7:1]};
				mem_wr = 1'b1;
				new_a = a ^ r;
			end
			OP_RLA: begin
				cf = m[7];
				r = {m[6:0], c};
				mem_wr = 1'b1;
				new_a = a & r;
			end
			OP_RRA: begin
				r = {c, m[7:1]};
				mem_wr = 1'b1;
				t = {1'b0, a} + {1'b0, r} + {8'd0, m[0]};
				cf = t[8];
				vf = (a[7] ^ t[7]) & (r[7] ^ t[7]);
				new_a = t[7:0];
			end
			default: ;
		endcase
		if (op == OP_DCP) begin
			nf = t[7];
			t[7:0] = a - r;
			nf = t[7];
			zf = (t[7:0] == 8'h00);
		end else if (op != OP_SAX) begin
			nf = new_a[7];
			zf = (new_a == 8'h00);
		end
		new_flags = {nf, vf, zf, cf};
		mem_byte = r;
	end
endmodule

>>> rtl/undocumented_opcode_executor.sv
// ----------------------------------------------------------------------------
// undocumented_opcode_executor
// Runs undocumented 6502 opcodes and memory/register items over a byte RAM.
// ----------------------------------------------------------------------------
// channel  direction  payload      handshake
// in       input      in_item_t    in_valid / in_stall
// out      output     out_item_t   out_valid / out_stall
//
// An item visits these states from its input beat to the next one: the idle
// state that takes the beat, two pointer reads and a pointer capture for
// indirect modes, the data read, execute, and done.
// The RAM holds no reset; A, X, Y, PC and flags reset to zero, the state to idle.
// A new item is taken as soon as the previous result sits in the output
// register and the engine is free; a stalled output beat holds off the next item.
// ----------------------------------------------------------------------------
module undocumented_opcode_executor import uoe_pkg::*; #(
	parameter int MEM_DEPTH = DEF_MEM_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);
`include "undocumented_opcode_executor_defines.svh"
	localparam int AW = $clog2(MEM_DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PLO  = 7'b0000010,
		ST_PHI  = 7'b0000100,
		ST_DRD  = 7'b0001000,
		ST_EXE  = 7'b0010000,
		ST_RDW  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t      state_q;
	in_item_t    item_q;
	dec_t        dec_q;
	logic [7:0]  a_q, x_q, y_q;
	logic [15:0] pc_q;
	logic [3:0]  flags_q;
	logic [15:0] ea_q;
	logic [7:0]  plo_q;
	logic [7:0]  rdat_q;
	logic        bad_q;
	out_item_t   res_q;
	logic        res_valid_q;

	logic [7:0]  mem [MEM_DEPTH];
	logic [7:0]  mem_rd;
	logic        mem_re, mem_we;
	logic [15:0] mem_raddr, mem_waddr;
	logic [7:0]  mem_wdata;

	logic        accept;
	logic [7:0]  zp;
	logic [7:0]  alu_m;
	logic [7:0]  alu_a, alu_x, alu_byte;
	logic [3:0]  alu_f;
	logic        alu_wr;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr[AW-1:0]] <= mem_wdata;
		if (mem_re)
			mem_rd <= mem[mem_raddr[AW-1:0]];
	end

	assign in_stall = (state_q != ST_IDLE) || (res_valid_q && out_stall);
	assign accept = in_valid && !in_stall;
	assign out_valid = res_valid_q;
	assign out_data = res_q;

	assign zp = (dec_q.mode == M_INDX) ? item_q.operand[7:0] + x_q : item_q.operand[7:0];

	// IMM reads the operand byte through the ALU: substitute it at the input
	assign alu_m = (dec_q.mode == M_IMM) ? item_q.operand[7:0] : mem_rd;

	uoe_alu u_alu (
		.op(dec_q.op), .a(a_q), .x(x_q), .flags(flags_q), .m(alu_m),
		.new_a(alu_a), .new_x(alu_x), .new_flags(alu_f), .mem_byte(alu_byte),
		.mem_wr(alu_wr)
	);

	always_comb begin
		mem_re = 1'b0;
		mem_raddr = 16'h0000;
		mem_we = 1'b0;
		mem_waddr = ea_q;
		mem_wdata = alu_byte;
		unique case (state_q)
			ST_PLO: begin
				mem_re = 1'b1;
				mem_raddr = {8'h00, zp};
			end
			ST_PHI: begin
				mem_re = 1'b1;
				mem_raddr = {8'h00, zp + 8'd1};
			end
			ST_DRD: begin
				mem_re = (item_q.kind == KIND_READ) || (dec_q.op != OP_SAX);
				mem_raddr = ea_q;
				if (item_q.kind == KIND_WRITE) begin
					mem_we = 1'b1;
					mem_wdata = item_q.write_byte;
				end
			end
			ST_EXE: mem_we = alu_wr;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			a_q <= 8'h00;
			x_q <= 8'h00;
			y_q <= 8'h00;
			pc_q <= 16'h0000;
			flags_q <= 4'h0;
		end else begin
			if (res_valid_q && !out_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) begin
					item_q <= in_data;
					dec_q <= decode(in_data.opcode);
					bad_q <= 1'b0;
					rdat_q <= 8'h00;
					ea_q <= in_data.operand;
					state_q <= ST_DRD;
					if (in_data.kind == KIND_LOAD) begin
						a_q <= in_data.load_a;
						x_q <= in_data.load_x;
						y_q <= in_data.load_y;
						pc_q <= in_data.load_pc;
						flags_q <= in_data.load_flags;
						state_q <= ST_DONE;
					end else if (in_data.kind == KIND_EXEC) begin
						automatic dec_t d = decode(in_data.opcode);
						state_q <= ST_DRD;
						if (!d.ok) begin
							bad_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							case (d.mode)
								M_ABSX: ea_q <= in_data.operand + {8'h00, x_q};
								M_ABSY: ea_q <= in_data.operand + {8'h00, y_q};
								M_ZP:   ea_q <= {8'h00, in_data.operand[7:0]};
								M_ZPX:  ea_q <= {8'h00, in_data.operand[7:0] + x_q};
								M_ZPY:  ea_q <= {8'h00, in_data.operand[7:0] + y_q};
								M_INDX, M_INDY: state_q <= ST_PLO;
								M_IMM:  state_q <= ST_EXE;
								default: ;
							endcase
						end
					end
				end
				ST_PLO: state_q <= ST_PHI;
				ST_PHI: begin
					plo_q <= mem_rd;
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					if (dec_q.mode == M_INDY)
						ea_q <= {mem_rd, plo_q} + {8'h00, y_q};
					else
						ea_q <= {mem_rd, plo_q};
					state_q <= ST_DRD;
				end
				ST_DRD: state_q <= (item_q.kind == KIND_EXEC) ? ST_EXE : ST_DONE;
				ST_EXE: begin
					a_q <= alu_a;
					x_q <= alu_x;
					flags_q <= alu_f;
					if (dec_q.mode == M_ABS || dec_q.mode == M_ABSX || dec_q.mode == M_ABSY)
						pc_q <= pc_q + 16'd3;
					else
						pc_q <= pc_q + 16'd2;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (item_q.kind == KIND_READ)
						rdat_q <= mem_rd;
					state_q <= ST_IDLE;
					res_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		res_q.out_a = a_q;
		res_q.out_x = x_q;
		res_q.out_y = y_q;
		res_q.out_pc = pc_q;
		res_q.out_flags = flags_q;
		res_q.read_data = rdat_q;
		res_q.bad_opcode = bad_q;
	end

	`UOE_ASSERT_IMP(a_no_accept_busy, state_q != ST_IDLE, in_stall)
	`UOE_ASSERT_NXT(a_done_gives_beat, state_q == ST_DONE, out_valid)
	`UOE_ASSERT_IMP(a_no_write_idle, state_q == ST_IDLE, !mem_we)
endmodule

>>> verif/undocumented_opcode_executor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// undocumented_opcode_executor_tb
// Drives execute, memory and register-load beats into the executor, predicts
// the register state after each one and compares it with every output beat.
// ----------------------------------------------------------------------------
module undocumented_opcode_executor_tb;
	import uoe_pkg::*;

	localparam int N_RANDOM = 2000;
	localparam int QUIET_TAIL = 300;
	localparam int HOLD_LEN = 400;
	localparam int IN_W = $bits(in_item_t);

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	undocumented_opcode_executor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// shadow CPU state
	logic [7:0]  cpu_a, cpu_x, cpu_y;
	logic [15:0] cpu_pc;
	logic [3:0]  cpu_p;
	logic [7:0]  ram [int];

	in_item_t  beats_pending [$];
	out_item_t states_expected [$];
	int        errors = 0;
	int        queued;
	bit        no_idle;
	bit        hold_go;
	int        hold_cycles;
	int        idle_left;

	// list of supported opcodes for random picks
	logic [7:0] legal_ops [29] = '{8'hAF, 8'hBF, 8'hA7, 8'hB7, 8'hB3, 8'h8F, 8'h87,
		8'h97, 8'h83, 8'hCF, 8'hC7, 8'hEF, 8'hE7, 8'h4B, 8'h6B, 8'h0B, 8'h0F, 8'h1F,
		8'h1B, 8'h07, 8'h17, 8'h03, 8'h13, 8'h4F, 8'h47, 8'h2F, 8'h27, 8'h6F, 8'h67};

	always #6 clk = ~clk;

	function automatic logic [7:0] ram_rd(logic [15:0] addr);
		return ram.exists(addr) ? ram[addr] : 8'h00;
	endfunction

	function automatic bit is_written(logic [15:0] addr);
		return ram.exists(addr);
	endfunction

	// decode by own table: opcode -> op/mode
	function automatic bit opcode_info(input logic [7:0] opc, output op_t op,
			output mode_t md);
		op = OP_LAX;
		md = M_ABS;
		case (opc)
			8'hAF: begin op = OP_LAX; md = M_ABS;  end
			8'hBF: begin op = OP_LAX; md = M_ABSY; end
			8'hA7: begin op = OP_LAX; md = M_ZP;   end
			8'hB7: begin op = OP_LAX; md = M_ZPY;  end
			8'hB3: begin op = OP_LAX; md = M_INDY; end
			8'h8F: begin op = OP_SAX; md = M_ABS;  end
			8'h87: begin op = OP_SAX; md = M_ZP;   end
			8'h97: begin op = OP_SAX; md = M_ZPY;  end
			8'h83: begin op = OP_SAX; md = M_INDX; end
			8'hCF: begin op = OP_DCP; md = M_ABS;  end
			8'hC7: begin op = OP_DCP; md = M_ZP;   end
			8'hEF: begin op = OP_ISC; md = M_ABS;  end
			8'hE7: begin op = OP_ISC; md = M_ZP;   end
			8'h4B: begin op = OP_ALR; md = M_IMM;  end
			8'h6B: begin op = OP_ARR; md = M_IMM;  end
			8'h0B: begin op = OP_ANC; md = M_IMM;  end
			8'h0F: begin op = OP_SLO; md = M_ABS;  end
			8'h1F: begin op = OP_SLO; md = M_ABSX; end
			8'h1B: begin op = OP_SLO; md = M_ABSY; end
			8'h07: begin op = OP_SLO; md = M_ZP;   end
			8'h17: begin op = OP_SLO; md = M_ZPX;  end
			8'h03: begin op = OP_SLO; md = M_INDX; end
			8'h13: begin op = OP_SLO; md = M_INDY; end
			8'h4F: begin op = OP_SRE; md = M_ABS;  end
			8'h47: begin op = OP_SRE; md = M_ZP;   end
			8'h2F: begin op = OP_RLA; md = M_ABS;  end
			8'h27: begin op = OP_RLA; md = M_ZP;   end
			8'h6F: begin op = OP_RRA; md = M_ABS;  end
			8'h67: begin op = OP_RRA; md = M_ZP;   end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// effective address; pointer bytes come from zero page
	function automatic logic [15:0] ea_of(mode_t md, logic [15:0] arg);
		logic [7:0] zp;
		case (md)
			M_ABS:  return arg;
			M_ABSX: return arg + 16'(cpu_x);
			M_ABSY: return arg + 16'(cpu_y);
			M_ZP:   return {8'h00, arg[7:0]};
			M_ZPX:  return {8'h00, arg[7:0] + cpu_x};
			M_ZPY:  return {8'h00, arg[7:0] + cpu_y};
			M_INDX: begin
				zp = arg[7:0] + cpu_x;
				return {ram_rd({8'h00, 8'(zp + 8'd1)}), ram_rd({8'h00, zp})};
			end
			M_INDY: begin
				zp = arg[7:0];
				return {ram_rd({8'h00, 8'(zp + 8'd1)}), ram_rd({8'h00, zp})}
					+ 16'(cpu_y);
			end
			default: return 16'h0000;
		endcase
	endfunction

	// operand bytes an execute beat reads before it can finish
	function automatic bit reads_defined(logic [7:0] opc, logic [15:0] arg);
		op_t op;
		mode_t md;
		logic [7:0] zp;
		if (!opcode_info(opc, op, md) || md == M_IMM)
			return 1'b1;
		if (md == M_INDX || md == M_INDY) begin
			zp = (md == M_INDX) ? arg[7:0] + cpu_x : arg[7:0];
			if (!is_written({8'h00, zp}) || !is_written({8'h00, 8'(zp + 8'd1)}))
				return 1'b0;
		end
		return (op == OP_SAX) || is_written(ea_of(md, arg));
	endfunction

	function automatic void set_nz(logic [7:0] v);
		cpu_p[3] = v[7];
		cpu_p[1] = (v == 8'h00);
	endfunction

	function automatic out_item_t cpu_step(in_item_t b);
		out_item_t r;
		op_t op;
		mode_t md;
		logic [15:0] ea;
		logic [7:0] m, res;
		logic [8:0] sum;
		logic c;
		r = '0;
		case (b.kind)
			KIND_EXEC: begin
				if (!opcode_info(b.opcode, op, md)) begin
					r.bad_opcode = 1'b1;
				end else begin
					ea = ea_of(md, b.operand);
					m = (md == M_IMM) ? b.operand[7:0] : ram_rd(ea);
					c = cpu_p[0];
					case (op)
						OP_LAX: begin cpu_a = m; cpu_x = m; set_nz(m); end
						OP_SAX: ram[ea] = cpu_a & cpu_x;
						OP_DCP: begin
							res = m - 8'd1;
							ram[ea] = res;
							cpu_p[0] = cpu_a >= res;
							set_nz(cpu_a - res);
						end
						OP_ISC: begin
							res = m + 8'd1;
							ram[ea] = res;
							sum = {1'b0, cpu_a} + {1'b0, ~res} + 9'(c);
							cpu_p[0] = sum[8];
							cpu_p[2] = (cpu_a[7] ^ sum[7]) & (~res[7] ^ sum[7]);
							cpu_a = sum[7:0];
							set_nz(cpu_a);
						end
						OP_ALR: begin
							res = cpu_a & m;
							cpu_p[0] = res[0];
							cpu_a = res >> 1;
							set_nz(cpu_a);
						end
						OP_ARR: begin
							res = cpu_a & m;
							cpu_a = {c, res[7:1]};
							cpu_p[0] = cpu_a[6];
							cpu_p[2] = cpu_a[6] ^ cpu_a[5];
							set_nz(cpu_a);
						end
						OP_ANC: begin
							cpu_a = cpu_a & m;
							cpu_p[0] = cpu_a[7];
							set_nz(cpu_a);
						end
						OP_SLO: begin
							cpu_p[0] = m[7];
							res = m << 1;
							ram[ea] = res;
							cpu_a = cpu_a | res;
							set_nz(cpu_a);
						end
						OP_SRE: begin
							cpu_p[0] = m[0];
							res = m >> 1;
							ram[ea] = res;
							cpu_a = cpu_a ^ res;
							set_nz(cpu_a);
						end
						OP_RLA: begin
							cpu_p[0] = m[7];
							res = {m[6:0], c};
							ram[ea] = res;
							cpu_a = cpu_a & res;
							set_nz(cpu_a);
						end
						OP_RRA: begin
							res = {c, m[7:1]};
							ram[ea] = res;
							sum = {1'b0, cpu_a} + {1'b0, res} + 9'(m[0]);
							cpu_p[0] = sum[8];
							cpu_p[2] = (cpu_a[7] ^ sum[7]) & (res[7] ^ sum[7]);
							cpu_a = sum[7:0];
							set_nz(cpu_a);
						end
						default: ;
					endcase
					cpu_pc = cpu_pc + ((md == M_ABS || md == M_ABSX || md == M_ABSY)
						? 16'd3 : 16'd2);
				end
			end
			KIND_WRITE: ram[b.operand] = b.write_byte;
			KIND_READ: r.read_data = ram_rd(b.operand);
			default: begin
				cpu_a = b.load_a;
				cpu_x = b.load_x;
				cpu_y = b.load_y;
				cpu_pc = b.load_pc;
				cpu_p = b.load_flags;
			end
		endcase
		r.out_a = cpu_a;
		r.out_x = cpu_x;
		r.out_y = cpu_y;
		r.out_pc = cpu_pc;
		r.out_flags = cpu_p;
		return r;
	endfunction

	// queue a beat; prediction runs at queue time since beats go in order
	task automatic push_beat(in_item_t b);
		states_expected.push_back(cpu_step(b));
		beats_pending.push_back(b);
		queued++;
	endtask

	task automatic push_write(logic [15:0] addr, logic [7:0] v);
		in_item_t b;
		b = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
		b.kind = KIND_WRITE;
		b.operand = addr;
		b.write_byte = v;
		push_beat(b);
	endtask

	task automatic push_load(logic [7:0] a, logic [7:0] x, logic [7:0] y,
			logic [15:0] pc, logic [3:0] p);
		in_item_t b;
		b = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
		b.kind = KIND_LOAD;
		b.load_a = a;
		b.load_x = x;
		b.load_y = y;
		b.load_pc = pc;
		b.load_flags = p;
		push_beat(b);
	endtask

	task automatic push_exec(logic [7:0] opc, logic [15:0] arg);
		in_item_t b;
		b = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
		b.kind = KIND_EXEC;
		b.opcode = opc;
		b.operand = arg;
		push_beat(b);
	endtask

	task automatic push_read(logic [15:0] addr);
		in_item_t b;
		b = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
		b.kind = KIND_READ;
		b.operand = addr;
		push_beat(b);
	endtask

	// address mostly in three small hot regions so that reads hit written bytes
	function automatic logic [15:0] hot_addr();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 255));
			1: return 16'($urandom_range(16'hFF00, 16'hFFFF));
			2: return 16'($urandom_range(16'h1000, 16'h10FF));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver: inserts random idle bursts unless no_idle is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			idle_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				in_valid <= 1'b0;
			end else if (beats_pending.size() > 0 &&
					(no_idle || $urandom_range(0, 5) != 0)) begin
				in_valid <= 1'b1;
				in_data <= beats_pending.pop_front();
			end else begin
				in_valid <= 1'b0;
				if (!no_idle)
					idle_left <= $urandom_range(0, 8);
			end
		end
	end

	// receiver stall: random bursts, one long hold
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_cycles <= 0;
		end else if (hold_go && hold_cycles < HOLD_LEN) begin
			hold_cycles <= hold_cycles + 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (states_expected.size() == 0) begin
				report_mismatch("unexpected beat", 16'h0, 16'h0);
			end else begin
				want = states_expected.pop_front();
				if (out_data.out_a !== want.out_a)
					report_mismatch("out_a", 16'(out_data.out_a), 16'(want.out_a));
				if (out_data.out_x !== want.out_x)
					report_mismatch("out_x", 16'(out_data.out_x), 16'(want.out_x));
				if (out_data.out_y !== want.out_y)
					report_mismatch("out_y", 16'(out_data.out_y), 16'(want.out_y));
				if (out_data.out_pc !== want.out_pc)
					report_mismatch("out_pc", out_data.out_pc, want.out_pc);
				if (out_data.out_flags !== want.out_flags)
					report_mismatch("out_flags", 16'(out_data.out_flags),
						16'(want.out_flags));
				if (out_data.read_data !== want.read_data)
					report_mismatch("read_data", 16'(out_data.read_data),
						16'(want.read_data));
				if (out_data.bad_opcode !== want.bad_opcode)
					report_mismatch("bad_opcode", 16'(out_data.bad_opcode),
						16'(want.bad_opcode));
			end
		end
	end

	initial begin
		#(12ns * 500000);
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [7:0] opc;
		logic [15:0] arg;
		int k;
		op_t op_pick;
		mode_t md_pick;
		clk = 1'b0;
		arst_n = 1'b0;
		queued = 0;
		no_idle = 1'b0;
		hold_go = 1'b0;
		cpu_a = '0; cpu_x = '0; cpu_y = '0; cpu_pc = '0; cpu_p = '0;

		// directed: pointers, wrap cases, every operation, bad opcode
		push_write(16'h0000, 8'hFF);
		push_write(16'h00FF, 8'h34);
		push_write(16'h0001, 8'h12);
		push_write(16'h1234, 8'h80);
		push_write(16'hFFFF, 8'h01);
		push_write(16'h1235, 8'h00);
		push_load(8'hFF, 8'h01, 8'h01, 16'hFFFE, 4'hF);
		push_exec(8'hB3, 16'hFFFF);        // (zp),Y pointer high byte wraps in zp
		push_exec(8'hBF, 16'hFFFE);        // abs,Y lands on the top address FFFF
		push_exec(8'h83, 16'h00FE);        // (zp,X) pointer high byte wraps in zp
		push_exec(8'hA7, 16'hAB00);
		push_exec(8'h17, 16'h00FF);        // zp,X wraps
		push_exec(8'hCF, 16'h1234);
		push_exec(8'hEF, 16'h1234);
		push_exec(8'h4B, 16'h00FF);
		push_exec(8'h6B, 16'h00FF);
		push_exec(8'h0B, 16'h0080);
		push_exec(8'h4F, 16'hFFFF);
		push_exec(8'h2F, 16'h1234);
		push_exec(8'h6F, 16'h1234);
		push_exec(8'h02, 16'hFFFF);        // unsupported
		push_exec(8'hFF, 16'h0000);
		push_read(16'h1234);
		push_load(8'h00, 8'h00, 8'h00, 16'h0000, 4'h0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (queued < N_RANDOM) begin
			// wait for space so predictions track the written set
			while (beats_pending.size() > 16)
				@(posedge clk);
			if (queued >= N_RANDOM / 3)
				hold_go = 1'b1;
			if (queued >= N_RANDOM * 9 / 10)
				no_idle = 1'b1;
			k = $urandom_range(0, 19);
			if (k < 4) begin
				push_write(hot_addr(), 8'($urandom));
			end else if (k < 5) begin
				push_load(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
					4'($urandom));
			end else if (k < 7) begin
				arg = hot_addr();
				if (is_written(arg))
					push_read(arg);
				else
					push_write(arg, 8'($urandom));
			end else begin
				opc = (k == 7) ? 8'($urandom) : legal_ops[$urandom_range(0, 28)];
				arg = hot_addr();
				if (reads_defined(opc, arg)) begin
					push_exec(opc, arg);
				end else begin
					// seed the bytes it needs, then queue it if they now cover its reads
					push_write({8'h00, arg[7:0]}, 8'($urandom));
					push_write({8'h00, 8'(arg[7:0] + 8'd1)}, 8'($urandom));
					push_write({8'h00, 8'(arg[7:0] + cpu_x)}, 8'($urandom));
					push_write({8'h00, 8'(arg[7:0] + cpu_x + 8'd1)}, 8'($urandom));
					if (reads_defined(opc, arg)) begin
						push_exec(opc, arg);
					end else begin
						if (opcode_info(opc, op_pick, md_pick))
							push_write(ea_of(md_pick, arg), 8'($urandom));
						if (reads_defined(opc, arg))
							push_exec(opc, arg);
					end
				end
			end
		end

		while (beats_pending.size() > 0 || in_valid)
			@(posedge clk);
		while (states_expected.size() > 0)
			@(posedge clk);
		repeat (QUIET_TAIL / 30) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
